### sv/dense_to_csr_builder_with_lookup_assert.svh
// assertion macros for the sparse row builder
`ifndef DENSE_TO_CSR_BUILDER_WITH_LOOKUP_ASSERT_SVH
`define DENSE_TO_CSR_BUILDER_WITH_LOOKUP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DCSR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// consequent must hold in the cycle after the antecedent
`define DCSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// expression must hold at every clock edge out of reset
`define DCSR_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant failed");

`endif

### sv/dcsr_pkg.sv
package dcsr_pkg;

   // storage defaults
   localparam int DEF_MAX_NONZEROS = 4096;
   localparam int DEF_MAX_ROWS     = 1024;

   // fixed limits
   localparam int MAX_COLS   = 1024;
   localparam int VALUE_BITS = 32;

   // port field widths
   localparam int ACTION_BITS    = 2;
   localparam int ELEM_BITS      = 32;
   localparam int QROW_BITS      = 10;
   localparam int QCOL_BITS      = 10;
   localparam int STATUS_BITS    = 2;
   localparam int RESULT_BITS    = 32;
   localparam int STORED_BITS    = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // internal widths
   localparam int SRC_BITS   = 16;
   localparam int WROWS_BITS = 11;
   localparam int WIDTH_BITS = 11;
   localparam int COL_BITS   = 10;
   localparam int PEND_BITS  = 11;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_RESTART = 2'd0,
      ACT_LOAD    = 2'd1,
      ACT_QUERY   = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      RSP_OK          = 2'd0,
      RSP_EARLY_QUERY = 2'd1,
      RSP_OVERFLOW    = 2'd2,
      RSP_EXTRA       = 2'd3
   } rsp_status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SOURCE_ROWS  = 2'd0,
      CSR_WINDOW_BEGIN = 2'd1,
      CSR_WINDOW_ROWS  = 2'd2,
      CSR_ROW_WIDTH    = 2'd3
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic fill_write;
      logic fill_sel_b;
      logic fill_begin_b;
      logic q_start;
      logic q_end;
      logic walk_check;
      logic walk_step;
      logic emit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fill_a_req;
      logic fill_b_req;
      logic query_go;
      logic fill_last;
      logic walk_empty;
      logic walk_hit;
      logic walk_last;
   } dp_status_type;

endpackage

### sv/dense_to_csr_builder_with_lookup.sv
// Sparse row builder: loads a row-major dense stream and answers element queries.
// Request channel (req_valid/req_ready) carries one transaction: restart, load one
// element, or query a row and column. Every transaction gives exactly one response
// on the rsp_valid/rsp_ready channel with status, value, stored count and the
// load-complete flag. The csr_ port sets the four geometry registers between loads.
// Restart, plain and ignored loads, idle requests, early and out-of-window queries
// go straight to the response register; no new request is taken before the last
// one's response is in that register. A load that starts a row's first entry also
// writes a pointer for each empty row waiting before it; the last element of the
// stream writes the trailing row pointers, up to window_rows + 1; a restart with
// zero rows or width does too. A query in the window scans its row's entries one
// by one, set by the single read port of the row start table and of the entry store.
// Reset clears counters and the load flag; the tables are not cleared and hold
// data only once written by a load. A stalled response waits in the output register
// while the next request is taken and worked; that one then waits to be sent.
`include "dense_to_csr_builder_with_lookup_assert.svh"

module dense_to_csr_builder_with_lookup #(
   parameter int MAX_NONZEROS = dcsr_pkg::DEF_MAX_NONZEROS,
   parameter int MAX_ROWS     = dcsr_pkg::DEF_MAX_ROWS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_we,
   input  logic        [dcsr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic        [dcsr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic        [dcsr_pkg::ACTION_BITS-1:0]    req_action,
   input  logic signed [dcsr_pkg::ELEM_BITS-1:0]      req_element_value,
   input  logic        [dcsr_pkg::QROW_BITS-1:0]      req_query_row,
   input  logic        [dcsr_pkg::QCOL_BITS-1:0]      req_query_col,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic        [dcsr_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic signed [dcsr_pkg::RESULT_BITS-1:0]    rsp_result_value,
   output logic        [dcsr_pkg::STORED_BITS-1:0]    rsp_stored_count,
   output logic                                       rsp_load_complete
);
   import dcsr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   dcsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // counters, tables and response register
   dcsr_datapath #(
      .MAX_NONZEROS (MAX_NONZEROS),
      .MAX_ROWS     (MAX_ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_action        (req_action),
      .req_element_value (req_element_value),
      .req_query_row     (req_query_row),
      .req_query_col     (req_query_col),
      .cmd               (cmd),
      .status            (status),
      .rsp_status        (rsp_status),
      .rsp_result_value  (rsp_result_value),
      .rsp_stored_count  (rsp_stored_count),
      .rsp_load_complete (rsp_load_complete)
   );

   // checks
   `DCSR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `DCSR_ASSERT_ALWAYS(a_one_command, clock, reset, $onehot0({cmd.accept, cmd.fill_write, cmd.q_start, cmd.q_end, cmd.walk_check, cmd.emit}))
   `DCSR_ASSERT_IMPLY(a_early_not_done, clock, reset, rsp_valid && (rsp_status == RSP_EARLY_QUERY), !rsp_load_complete)
   `DCSR_ASSERT_IMPLY(a_value_only_on_query, clock, reset, rsp_valid && (rsp_result_value != '0), (rsp_status == RSP_OK) && rsp_load_complete)

endmodule

### sv/dcsr_ctrl.sv
module dcsr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  dcsr_pkg::dp_status_type status,
   output dcsr_pkg::dp_cmd_type    cmd
);
   import dcsr_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_FILL_A  = 7'b0000010,
      S_FILL_B  = 7'b0000100,
      S_Q_START = 7'b0001000,
      S_Q_END   = 7'b0010000,
      S_WALK    = 7'b0100000,
      S_EMIT    = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           b_pend_ff, b_pend_in;
   logic           rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   // sequencing of one transaction
   always_comb begin
      state_in     = state_ff;
      b_pend_in    = b_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               b_pend_in  = status.fill_b_req;
               if (status.fill_a_req) begin
                  state_in = S_FILL_A;
               end else if (status.fill_b_req) begin
                  state_in = S_FILL_B;
               end else if (status.query_go) begin
                  state_in = S_Q_START;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_FILL_A: begin
            cmd.fill_write = 1'b1;
            if (status.fill_last) begin
               if (b_pend_ff) begin
                  cmd.fill_begin_b = 1'b1;
                  state_in         = S_FILL_B;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_FILL_B: begin
            cmd.fill_write = 1'b1;
            cmd.fill_sel_b = 1'b1;
            if (status.fill_last) begin
               state_in = S_EMIT;
            end
         end
         S_Q_START: begin
            cmd.q_start = 1'b1;
            state_in    = S_Q_END;
         end
         S_Q_END: begin
            cmd.q_end = 1'b1;
            state_in  = status.walk_empty ? S_EMIT : S_WALK;
         end
         S_WALK: begin
            cmd.walk_check = 1'b1;
            if (status.walk_hit || status.walk_last) begin
               state_in = S_EMIT;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         b_pend_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b_pend_ff    <= b_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/dcsr_datapath.sv
module dcsr_datapath #(
   parameter int MAX_NONZEROS = dcsr_pkg::DEF_MAX_NONZEROS,
   parameter int MAX_ROWS     = dcsr_pkg::DEF_MAX_ROWS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic        [dcsr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic        [dcsr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic        [dcsr_pkg::ACTION_BITS-1:0]    req_action,
   input  logic signed [dcsr_pkg::ELEM_BITS-1:0]      req_element_value,
   input  logic        [dcsr_pkg::QROW_BITS-1:0]      req_query_row,
   input  logic        [dcsr_pkg::QCOL_BITS-1:0]      req_query_col,
   input  dcsr_pkg::dp_cmd_type                       cmd,
   output dcsr_pkg::dp_status_type                    status,
   output logic        [dcsr_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic signed [dcsr_pkg::RESULT_BITS-1:0]    rsp_result_value,
   output logic        [dcsr_pkg::STORED_BITS-1:0]    rsp_stored_count,
   output logic                                       rsp_load_complete
);
   import dcsr_pkg::*;

   localparam int CW  = $clog2(MAX_NONZEROS + 1);
   localparam int AW  = $clog2(MAX_NONZEROS);
   localparam int RIW = $clog2(MAX_ROWS + 1);
   localparam logic [PEND_BITS-1:0] PEND_SAT = '1;

   // configuration registers
   logic [SRC_BITS-1:0]   src_rows_ff, src_rows_in;
   logic [SRC_BITS-1:0]   win_begin_ff, win_begin_in;
   logic [WROWS_BITS-1:0] win_rows_ff, win_rows_in;
   logic [WIDTH_BITS-1:0] row_width_ff, row_width_in;

   // load progress
   logic [SRC_BITS-1:0]  src_cnt_ff, src_cnt_in;
   logic [COL_BITS-1:0]  col_cnt_ff, col_cnt_in;
   logic [CW-1:0]        nz_cnt_ff, nz_cnt_in;
   logic [PEND_BITS-1:0] pend_ff, pend_in;
   logic                 row_has_ff, row_has_in;
   logic                 load_done_ff, load_done_in;

   // per transaction
   rsp_status_type     item_status_ff, item_status_in;
   logic [RESULT_BITS-1:0] result_ff;
   logic [RIW-1:0]     qr_ff;
   logic [COL_BITS-1:0] qc_ff;

   // pointer fill ranges
   logic [RIW-1:0] fill_addr_ff, a_hi_ff, b_lo_ff, b_hi_ff;
   logic [CW-1:0]  a_val_ff, b_val_ff;

   // row walk
   logic [CW-1:0] start_ff, end_ff, ptr_ff;

   // stores
   logic [CW-1:0]         row_mem [MAX_ROWS+1];
   logic [CW-1:0]         rs_rd_ff;
   logic [VALUE_BITS-1:0] val_mem [MAX_NONZEROS];
   logic [COL_BITS-1:0]   col_mem [MAX_NONZEROS];
   logic [VALUE_BITS-1:0] ev_rd_ff;
   logic [COL_BITS-1:0]   ec_rd_ff;

   // response payload
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [RESULT_BITS-1:0] rsp_result_ff;
   logic [STORED_BITS-1:0] rsp_count_ff;
   logic                   rsp_done_ff;

   // combinational terms
   action_type            act;
   logic [RIW-1:0]        used_rows;
   logic [WIDTH_BITS-1:0] used_width;
   logic [SRC_BITS-1:0]   row_off, span, src_next;
   logic [RIW-1:0]        r, a_lo, processed, from_row, b_lo_sel;
   logic                  in_win, load_active, store_try, overflow, do_store;
   logic                  row_end, rhe_after, pend_bump, finish, restart_fill;
   logic [PEND_BITS-1:0]  pend_mid, pend_final, waiting;
   logic [VALUE_BITS-1:0] elem_value;
   logic [CW-1:0]         count_new, end_clip;
   logic [RIW-1:0]        rs_raddr;
   logic [AW-1:0]         ent_raddr;

   assign act        = action_type'(req_action);
   assign elem_value = req_element_value[VALUE_BITS-1:0];

   // clamped window and width
   assign used_rows  = (int'(win_rows_ff) > MAX_ROWS) ? RIW'(MAX_ROWS) : RIW'(win_rows_ff);
   assign used_width = (row_width_ff > WIDTH_BITS'(MAX_COLS)) ? WIDTH_BITS'(MAX_COLS)
                                                              : row_width_ff;

   // element position and store decision
   assign row_off     = src_cnt_ff - win_begin_ff;
   assign in_win      = (src_cnt_ff >= win_begin_ff) && (int'(row_off) < int'(used_rows));
   assign r           = RIW'(row_off);
   assign load_active = (act == ACT_LOAD) && !load_done_ff;
   assign store_try   = load_active && in_win && (elem_value != '0);
   assign overflow    = store_try && (int'(nz_cnt_ff) >= MAX_NONZEROS);
   assign do_store    = store_try && !overflow;
   assign count_new   = nz_cnt_ff + CW'(do_store);

   // first entry of a row points the waiting empty rows at it
   assign a_lo = (int'(pend_ff) > int'(r)) ? '0 : RIW'(int'(r) + 1 - int'(pend_ff));

   // end of row bookkeeping
   assign row_end    = load_active && ((int'(col_cnt_ff) + 1) >= int'(used_width));
   assign rhe_after  = row_has_ff || do_store;
   assign pend_mid   = (do_store && !row_has_ff) ? PEND_BITS'(1) : pend_ff;
   assign pend_bump  = row_end && in_win && !rhe_after && (pend_mid != PEND_SAT);
   assign pend_final = pend_mid + PEND_BITS'(pend_bump);
   assign src_next   = src_cnt_ff + 1'b1;
   assign finish     = row_end && ((src_next >= src_rows_ff) || (src_next == '0));

   // trailing rows get the final count
   assign span      = src_rows_ff - win_begin_ff;
   assign processed = (src_rows_ff < win_begin_ff) ? '0 :
                      (int'(span) > int'(used_rows)) ? used_rows : RIW'(span);
   assign waiting   = pend_final - 1'b1;
   assign from_row  = (int'(waiting) > int'(processed)) ? '0
                      : RIW'(int'(processed) - int'(waiting));

   assign restart_fill = (src_rows_ff == '0) || (used_width == '0);
   assign b_lo_sel     = (act == ACT_RESTART) ? '0 : from_row;

   // query row end pointer, clipped to the store
   assign end_clip = (int'(rs_rd_ff) > MAX_NONZEROS) ? CW'(MAX_NONZEROS) : rs_rd_ff;

   // status toward the controller
   always_comb begin
      status.fill_a_req = do_store && !row_has_ff;
      status.fill_b_req = ((act == ACT_RESTART) && restart_fill) || finish;
      status.query_go   = (act == ACT_QUERY) && load_done_ff
                          && (int'(req_query_row) < int'(used_rows))
                          && (int'(req_query_col) < int'(used_width));
      status.fill_last  = fill_addr_ff == (cmd.fill_sel_b ? b_hi_ff : a_hi_ff);
      status.walk_empty = start_ff >= end_clip;
      status.walk_hit   = ec_rd_ff == qc_ff;
      status.walk_last  = ptr_ff >= end_ff;
   end

   // transaction status code
   always_comb begin
      item_status_in = RSP_OK;
      unique case (act)
         ACT_RESTART: item_status_in = RSP_OK;
         ACT_LOAD: begin
            if (load_done_ff) begin
               item_status_in = RSP_EXTRA;
            end else if (overflow) begin
               item_status_in = RSP_OVERFLOW;
            end else begin
               item_status_in = RSP_OK;
            end
         end
         ACT_QUERY:   item_status_in = load_done_ff ? RSP_OK : RSP_EARLY_QUERY;
         ACT_NONE:    item_status_in = RSP_OK;
         default:     item_status_in = RSP_OK;
      endcase
   end

   // configuration writes
   always_comb begin
      src_rows_in  = src_rows_ff;
      win_begin_in = win_begin_ff;
      win_rows_in  = win_rows_ff;
      row_width_in = row_width_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SOURCE_ROWS:  src_rows_in  = csr_wdata[SRC_BITS-1:0];
            CSR_WINDOW_BEGIN: win_begin_in = csr_wdata[SRC_BITS-1:0];
            CSR_WINDOW_ROWS:  win_rows_in  = csr_wdata[WROWS_BITS-1:0];
            CSR_ROW_WIDTH:    row_width_in = csr_wdata[WIDTH_BITS-1:0];
            default:          src_rows_in  = src_rows_ff;
         endcase
      end
   end

   // load progress next state
   always_comb begin
      src_cnt_in   = src_cnt_ff;
      col_cnt_in   = col_cnt_ff;
      nz_cnt_in    = nz_cnt_ff;
      pend_in      = pend_ff;
      row_has_in   = row_has_ff;
      load_done_in = load_done_ff;
      if (cmd.accept) begin
         if (act == ACT_RESTART) begin
            src_cnt_in   = '0;
            col_cnt_in   = '0;
            nz_cnt_in    = '0;
            pend_in      = PEND_BITS'(1);
            row_has_in   = 1'b0;
            load_done_in = restart_fill;
         end else if (load_active) begin
            nz_cnt_in  = count_new;
            pend_in    = pend_final;
            row_has_in = row_end ? 1'b0 : rhe_after;
            if (row_end) begin
               col_cnt_in = '0;
               src_cnt_in = src_next;
            end else begin
               col_cnt_in = col_cnt_ff + 1'b1;
            end
            if (finish) begin
               load_done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_rows_ff  <= '0;
         win_begin_ff <= '0;
         win_rows_ff  <= '0;
         row_width_ff <= '0;
         src_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         nz_cnt_ff    <= '0;
         pend_ff      <= PEND_BITS'(1);
         row_has_ff   <= 1'b0;
         load_done_ff <= 1'b0;
      end else begin
         src_rows_ff  <= src_rows_in;
         win_begin_ff <= win_begin_in;
         win_rows_ff  <= win_rows_in;
         row_width_ff <= row_width_in;
         src_cnt_ff   <= src_cnt_in;
         col_cnt_ff   <= col_cnt_in;
         nz_cnt_ff    <= nz_cnt_in;
         pend_ff      <= pend_in;
         row_has_ff   <= row_has_in;
         load_done_ff <= load_done_in;
      end
   end

   // transaction payload, fill ranges and walk pointers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_status_ff <= item_status_in;
         result_ff      <= '0;
         qr_ff          <= RIW'(req_query_row);
         qc_ff          <= req_query_col;
         a_hi_ff        <= r;
         a_val_ff       <= nz_cnt_ff;
         b_lo_ff        <= b_lo_sel;
         b_hi_ff        <= used_rows;
         b_val_ff       <= (act == ACT_RESTART) ? '0 : count_new;
         fill_addr_ff   <= status.fill_a_req ? a_lo : b_lo_sel;
      end else begin
         if (cmd.fill_begin_b) begin
            fill_addr_ff <= b_lo_ff;
         end else if (cmd.fill_write) begin
            fill_addr_ff <= fill_addr_ff + 1'b1;
         end
         if (cmd.walk_check && status.walk_hit) begin
            result_ff <= RESULT_BITS'(ev_rd_ff);
         end
      end
      if (cmd.q_start) begin
         start_ff <= rs_rd_ff;
      end
      if (cmd.q_end) begin
         end_ff <= end_clip;
         ptr_ff <= start_ff + 1'b1;
      end else if (cmd.walk_step) begin
         ptr_ff <= ptr_ff + 1'b1;
      end
   end

   // row start table
   assign rs_raddr = cmd.accept ? RIW'(req_query_row) : qr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.fill_write) begin
         row_mem[fill_addr_ff] <= cmd.fill_sel_b ? b_val_ff : a_val_ff;
      end
      rs_rd_ff <= row_mem[rs_raddr];
   end

   // entry store
   assign ent_raddr = cmd.q_end ? start_ff[AW-1:0] : ptr_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.accept && do_store) begin
         val_mem[nz_cnt_ff[AW-1:0]] <= elem_value;
         col_mem[nz_cnt_ff[AW-1:0]] <= col_cnt_ff;
      end
      ev_rd_ff <= val_mem[ent_raddr];
      ec_rd_ff <= col_mem[ent_raddr];
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= item_status_ff;
         rsp_result_ff <= result_ff;
         rsp_count_ff  <= STORED_BITS'(nz_cnt_ff);
         rsp_done_ff   <= load_done_ff;
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_result_value  = rsp_result_ff;
   assign rsp_stored_count  = rsp_count_ff;
   assign rsp_load_complete = rsp_done_ff;

endmodule

### tb/sv/tb_dense_to_csr_builder_with_lookup.sv
module tb_dense_to_csr_builder_with_lookup;
   timeunit 1ns;
   timeprecision 1ps;

   import dcsr_pkg::*;

   localparam int NZ_SLOTS     = DEF_MAX_NONZEROS;
   localparam int ROW_SLOTS    = DEF_MAX_ROWS;
   localparam int COL_SLOTS    = MAX_COLS;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int RANDOM_ITEMS = 1450;
   localparam int LONG_HOLD    = 400;

   // one response as the block should give it
   typedef struct {
      rsp_status_type   status;
      logic signed [31:0] value;
      logic [12:0]      count;
      logic             complete;
   } csr_answer_t;

   // one line of the stimulus script: a register write or a transaction
   typedef struct {
      bit            is_write;
      csr_index_type reg_idx;
      logic [15:0]   reg_data;
      action_type    act;
      logic [31:0]   elem;
      logic [9:0]    qrow;
      logic [9:0]    qcol;
      bit            typed;
      csr_answer_t   typed_answer;
   } script_row_t;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [1:0]           csr_index;
   logic [15:0]          csr_wdata;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_action;
   logic signed [31:0]   req_element_value;
   logic [9:0]           req_query_row;
   logic [9:0]           req_query_col;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_status;
   logic signed [31:0]   rsp_result_value;
   logic [12:0]          rsp_stored_count;
   logic                 rsp_load_complete;

   dense_to_csr_builder_with_lookup u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_element_value (req_element_value),
      .req_query_row     (req_query_row),
      .req_query_col     (req_query_col),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_result_value  (rsp_result_value),
      .rsp_stored_count  (rsp_stored_count),
      .rsp_load_complete (rsp_load_complete)
   );

   // shadow geometry registers
   int unsigned cfg_src_rows   = 0;
   int unsigned cfg_win_begin  = 0;
   int unsigned cfg_win_rows   = 0;
   int unsigned cfg_row_width  = 0;

   // shadow sparse store and load progress
   logic [31:0] store_value [0:NZ_SLOTS-1];
   logic [9:0]  store_col   [0:NZ_SLOTS-1];
   logic [12:0] row_ptr     [0:ROW_SLOTS];
   int unsigned cur_src_row        = 0;
   int unsigned cur_col            = 0;
   int unsigned nz_count           = 0;
   int unsigned empty_rows_waiting = 1;
   bit          row_open           = 0;
   bit          loaded             = 0;

   // responses still owed by the block, oldest first
   csr_answer_t csr_answers [$];

   int          cycle_count    = 0;
   int          mismatch_count = 0;
   int          burst_left     = 0;
   int          served_items   = 0;
   bit          long_hold_due  = 0;
   int          n_load, n_query, n_restart, n_idle, n_phase;
   int          n_overflow_seen, n_extra_seen, n_early_seen, n_hits_seen;

   function automatic int unsigned kept_rows();
      return (cfg_win_rows < ROW_SLOTS) ? cfg_win_rows : ROW_SLOTS;
   endfunction

   function automatic int unsigned kept_cols();
      return (cfg_row_width < COL_SLOTS) ? cfg_row_width : COL_SLOTS;
   endfunction

   // point every row from first up to the end marker at the current count
   function automatic void point_rows_from(input int unsigned first);
      int unsigned r;
      for (r = first; r <= kept_rows() && r <= ROW_SLOTS; r++) row_ptr[r] = nz_count[12:0];
   endfunction

   // last element taken: trailing rows get the final count
   function automatic void close_load();
      int unsigned done_rows;
      int unsigned waiting;
      done_rows = 0;
      waiting   = empty_rows_waiting - 1;
      if (cfg_src_rows >= cfg_win_begin) begin
         done_rows = cfg_src_rows - cfg_win_begin;
         if (done_rows > kept_rows()) done_rows = kept_rows();
      end
      point_rows_from((waiting > done_rows) ? 0 : done_rows - waiting);
      loaded = 1;
   endfunction

   // one dense element into the sparse store
   function automatic rsp_status_type take_element(input logic [31:0] v);
      rsp_status_type st;
      int unsigned    src_row;
      int unsigned    r;
      int unsigned    k;
      bit             in_win;
      st      = RSP_OK;
      src_row = cur_src_row;
      in_win  = (src_row >= cfg_win_begin) && ((src_row - cfg_win_begin) < kept_rows());
      r       = src_row - cfg_win_begin;
      if (in_win && v != 0) begin
         if (nz_count >= NZ_SLOTS) begin
            st = RSP_OVERFLOW;
         end else begin
            // first entry of the row also closes the empty rows before it
            if (!row_open) begin
               for (k = 0; k < empty_rows_waiting && k <= r; k++)
                  if (r - k <= ROW_SLOTS) row_ptr[r - k] = nz_count[12:0];
               empty_rows_waiting = 1;
               row_open = 1;
            end
            store_value[nz_count] = v;
            store_col[nz_count]   = cur_col[9:0];
            nz_count++;
         end
      end
      // advance the stream position
      if (cur_col + 1 >= kept_cols()) begin
         if (in_win && !row_open && empty_rows_waiting < 'h7ff) empty_rows_waiting++;
         row_open    = 0;
         cur_col     = 0;
         cur_src_row = (cur_src_row + 1) & 'hffff;
         if (cur_src_row >= cfg_src_rows || cur_src_row == 0) close_load();
      end else begin
         cur_col = (cur_col + 1) & 'h3ff;
      end
      return st;
   endfunction

   // response of the block to one accepted transaction
   function automatic csr_answer_t csr_answer_for(input action_type act,
                                                  input logic [31:0] v,
                                                  input logic [9:0] qr,
                                                  input logic [9:0] qc);
      csr_answer_t a;
      int unsigned k;
      int unsigned stop;
      a.status = RSP_OK;
      a.value  = '0;
      case (act)
         ACT_RESTART: begin
            cur_src_row        = 0;
            cur_col            = 0;
            nz_count           = 0;
            empty_rows_waiting = 1;
            row_open           = 0;
            loaded             = 0;
            if (cfg_src_rows == 0 || kept_cols() == 0) begin
               point_rows_from(0);
               loaded = 1;
            end
         end
         ACT_LOAD: begin
            a.status = loaded ? RSP_EXTRA : take_element(v);
         end
         ACT_QUERY: begin
            if (!loaded) begin
               a.status = RSP_EARLY_QUERY;
            end else if (qr < kept_rows() && qc < kept_cols()) begin
               // walk the entries of the asked row
               k    = row_ptr[qr];
               stop = row_ptr[int'(qr) + 1];
               if (stop > NZ_SLOTS) stop = NZ_SLOTS;
               while (k < stop) begin
                  if (store_col[k] == qc) begin
                     a.value = store_value[k];
                     break;
                  end
                  k++;
               end
            end
         end
         default: ;
      endcase
      a.count    = nz_count[12:0];
      a.complete = loaded;
      return a;
   endfunction

   function automatic script_row_t req_row(input action_type act, input logic [31:0] elem,
                                           input logic [9:0] qr, input logic [9:0] qc);
      script_row_t s;
      s.is_write              = 0;
      s.reg_idx               = CSR_SOURCE_ROWS;
      s.reg_data              = '0;
      s.act                   = act;
      s.elem                  = elem;
      s.qrow                  = qr;
      s.qcol                  = qc;
      s.typed                 = 0;
      s.typed_answer.status   = RSP_OK;
      s.typed_answer.value    = '0;
      s.typed_answer.count    = '0;
      s.typed_answer.complete = 0;
      return s;
   endfunction

   function automatic script_row_t fixed_row(input action_type act, input logic [31:0] elem,
                                             input logic [9:0] qr, input logic [9:0] qc,
                                             input rsp_status_type st, input logic [31:0] val,
                                             input logic [12:0] cnt, input logic done);
      script_row_t s;
      s                       = req_row(act, elem, qr, qc);
      s.typed                 = 1;
      s.typed_answer.status   = st;
      s.typed_answer.value    = val;
      s.typed_answer.count    = cnt;
      s.typed_answer.complete = done;
      return s;
   endfunction

   function automatic script_row_t write_row(input csr_index_type idx, input logic [15:0] data);
      script_row_t s;
      s          = req_row(ACT_NONE, '0, '0, '0);
      s.is_write = 1;
      s.reg_idx  = idx;
      s.reg_data = data;
      return s;
   endfunction

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= 30)
         $display("mismatch at cycle %0d: %s got %0d wanted %0d", cycle_count, what, got, want);
   endtask

   // offer one transaction in bursts with random gaps, predict it on acceptance
   task automatic send_req(input script_row_t row);
      int          gap;
      csr_answer_t predicted;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(60, 200);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 20);
            gap        = $urandom_range(0, 6);
         end
         if (gap > 0) begin
            @(negedge clock) req_valid = 0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid         = 1;
      req_action        = row.act;
      req_element_value = row.elem;
      req_query_row     = row.qrow;
      req_query_col     = row.qcol;
      do @(posedge clock); while (!req_ready);
      predicted = csr_answer_for(row.act, row.elem, row.qrow, row.qcol);
      csr_answers.push_back(row.typed ? row.typed_answer : predicted);
      case (row.act)
         ACT_RESTART: n_restart++;
         ACT_LOAD:    n_load++;
         ACT_QUERY:   n_query++;
         default:     n_idle++;
      endcase
      if (row.act != ACT_NONE) served_items++;
   endtask

   // stop offering and wait until every owed response is out
   task automatic wait_answers_out();
      @(negedge clock) req_valid = 0;
      burst_left = 0;
      while (csr_answers.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input int unsigned data);
      @(negedge clock);
      csr_we    = 1;
      csr_index = idx;
      csr_wdata = data[15:0];
      @(negedge clock) csr_we = 0;
      case (idx)
         CSR_SOURCE_ROWS:  cfg_src_rows  = data & 'hffff;
         CSR_WINDOW_BEGIN: cfg_win_begin = data & 'hffff;
         CSR_WINDOW_ROWS:  cfg_win_rows  = data & 'h7ff;
         default:          cfg_row_width = data & 'h7ff;
      endcase
   endtask

   // row-major element stream with the odd stray transaction mixed in
   task automatic load_stream(input int unsigned n, input int zero_pct);
      int unsigned i;
      logic [31:0] v;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1) == 0)
               send_req(req_row(ACT_QUERY, $urandom, 10'($urandom), 10'($urandom)));
            else
               send_req(req_row(ACT_NONE, $urandom, 10'($urandom), 10'($urandom)));
         end
         if ($urandom_range(0, 99) < zero_pct) begin
            v = '0;
         end else begin
            case ($urandom_range(0, 9))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7fff_ffff;
               2:       v = 32'hffff_ffff;
               3:       v = 32'h0000_0001;
               default: v = $urandom;
            endcase
         end
         send_req(req_row(ACT_LOAD, v, 10'($urandom), 10'($urandom)));
      end
   endtask

   // one geometry setting: configure, restart, stream, then look entries up
   task automatic run_phase(input int unsigned src, input int unsigned wb,
                            input int unsigned wr, input int unsigned wd,
                            input int zero_pct, input int n_ask, input bit hold_receiver);
      int unsigned total;
      int          i;
      logic [9:0]  qr;
      logic [9:0]  qc;
      n_phase++;
      wait_answers_out();
      csr_write(CSR_SOURCE_ROWS, src);
      csr_write(CSR_WINDOW_BEGIN, wb);
      csr_write(CSR_WINDOW_ROWS, wr);
      csr_write(CSR_ROW_WIDTH, wd);
      send_req(req_row(ACT_RESTART, $urandom, 10'($urandom), 10'($urandom)));
      if (hold_receiver) long_hold_due = 1;
      total = src * kept_cols();
      if (src == 'hffff) begin
         // stream far too long to finish: take part of it, then start over
         load_stream($urandom_range(10, 40), zero_pct);
         send_req(req_row(ACT_RESTART, $urandom, 10'($urandom), 10'($urandom)));
      end else begin
         if (total > 0 && $urandom_range(0, 7) == 0) begin
            load_stream($urandom_range(0, total - 1), zero_pct);
            send_req(req_row(ACT_RESTART, $urandom, 10'($urandom), 10'($urandom)));
         end
         load_stream(total, zero_pct);
         if ($urandom_range(0, 3) == 0)
            send_req(req_row(ACT_LOAD, $urandom, 10'($urandom), 10'($urandom)));
      end
      if (hold_receiver || $urandom_range(0, 2) == 0) wait_answers_out();
      // lookups, mostly inside the window
      for (i = 0; i < n_ask; i++) begin
         if (kept_rows() > 0 && kept_cols() > 0 && $urandom_range(0, 3) != 0) begin
            qr = 10'($urandom_range(0, kept_rows() - 1));
            qc = 10'($urandom_range(0, kept_cols() - 1));
         end else begin
            qr = 10'($urandom);
            qc = 10'($urandom);
         end
         send_req(req_row(ACT_QUERY, $urandom, qr, qc));
      end
   endtask

   // clock
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("dense_to_csr_builder_with_lookup verification failed");
      $finish;
   end

   // response side stalls on its own pattern, with one long hold-off on request
   initial begin : response_stall
      int hold_left;
      int mode;
      int mode_left;
      int tick;
      bit hold_taken;
      hold_left  = 0;
      mode       = 0;
      mode_left  = 0;
      tick       = 0;
      hold_taken = 0;
      rsp_ready  = 0;
      forever begin
         @(negedge clock);
         if (long_hold_due && !hold_taken) begin
            hold_taken = 1;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_ready = 0;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(8, 80);
               tick      = 0;
            end
            mode_left--;
            tick++;
            case (mode)
               0:       rsp_ready = 1;
               1:       rsp_ready = $urandom_range(0, 1);
               2:       rsp_ready = ($urandom_range(0, 4) != 0);
               default: rsp_ready = (tick % 3 == 0);
            endcase
         end
      end
   end

   // compare each response transaction with the oldest owed one
   initial begin : response_check
      csr_answer_t want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (csr_answers.size() == 0) begin
               flag_mismatch("response with nothing owed, status", rsp_status, 0);
            end else begin
               want = csr_answers.pop_front();
               if (rsp_status != want.status)
                  flag_mismatch("status", rsp_status, want.status);
               if (rsp_result_value !== want.value)
                  flag_mismatch("result_value", rsp_result_value, want.value);
               if (rsp_stored_count !== want.count)
                  flag_mismatch("stored_count", rsp_stored_count, want.count);
               if (rsp_load_complete !== want.complete)
                  flag_mismatch("load_complete", rsp_load_complete, want.complete);
               case (rsp_status)
                  RSP_OVERFLOW:    n_overflow_seen++;
                  RSP_EXTRA:       n_extra_seen++;
                  RSP_EARLY_QUERY: n_early_seen++;
                  default:         if (rsp_result_value != 0) n_hits_seen++;
               endcase
            end
         end
      end
   end

   // stimulus
   initial begin : stimulus
      script_row_t script [$];
      int          random_base;
      int unsigned src;
      int unsigned wb;
      int unsigned wr;
      int unsigned wd;
      int unsigned src_small;
      reset             = 1;
      csr_we            = 0;
      csr_index         = CSR_SOURCE_ROWS;
      csr_wdata         = '0;
      req_valid         = 0;
      req_action        = ACT_NONE;
      req_element_value = '0;
      req_query_row     = '0;
      req_query_col     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset = 0;

      // out of reset: all geometry zero, nothing loaded
      script.push_back(fixed_row(ACT_QUERY, 0, 0, 0, RSP_EARLY_QUERY, 0, 0, 0));
      script.push_back(fixed_row(ACT_NONE, 32'h5a5a_5a5a, 10'h3ff, 10'h3ff, RSP_OK, 0, 0, 0));
      script.push_back(fixed_row(ACT_LOAD, 5, 0, 0, RSP_OK, 0, 0, 1));
      script.push_back(fixed_row(ACT_LOAD, 32'hffff_ffff, 0, 0, RSP_EXTRA, 0, 0, 1));
      script.push_back(fixed_row(ACT_QUERY, 0, 10'h3ff, 10'h3ff, RSP_OK, 0, 0, 1));
      script.push_back(fixed_row(ACT_RESTART, 0, 0, 0, RSP_OK, 0, 0, 1));
      // 3 source rows of 2 columns, window on rows 1 and 2
      script.push_back(write_row(CSR_SOURCE_ROWS, 16'd3));
      script.push_back(write_row(CSR_WINDOW_BEGIN, 16'd1));
      script.push_back(write_row(CSR_WINDOW_ROWS, 16'd2));
      script.push_back(write_row(CSR_ROW_WIDTH, 16'd2));
      script.push_back(fixed_row(ACT_RESTART, 0, 0, 0, RSP_OK, 0, 0, 0));
      script.push_back(fixed_row(ACT_QUERY, 0, 0, 0, RSP_EARLY_QUERY, 0, 0, 0));
      // row ahead of the window, an empty window row, then a full one
      script.push_back(req_row(ACT_LOAD, 32'd7, 0, 0));
      script.push_back(req_row(ACT_LOAD, 32'hffff_ffff, 0, 0));
      script.push_back(req_row(ACT_LOAD, 32'd0, 0, 0));
      script.push_back(req_row(ACT_LOAD, 32'd0, 0, 0));
      script.push_back(req_row(ACT_LOAD, 32'h8000_0000, 0, 0));
      script.push_back(req_row(ACT_LOAD, 32'h7fff_ffff, 0, 0));
      script.push_back(req_row(ACT_LOAD, 32'd9, 0, 0));
      script.push_back(req_row(ACT_QUERY, 0, 0, 0));
      script.push_back(req_row(ACT_QUERY, 0, 0, 1));
      script.push_back(req_row(ACT_QUERY, 0, 1, 0));
      script.push_back(req_row(ACT_QUERY, 0, 1, 1));
      script.push_back(req_row(ACT_QUERY, 0, 2, 0));
      script.push_back(req_row(ACT_QUERY, 0, 1, 2));
      script.push_back(req_row(ACT_QUERY, 0, 10'h3ff, 10'h3ff));
      script.push_back(req_row(ACT_NONE, 32'ha5a5_a5a5, 10'h2aa, 10'h155));
      foreach (script[i]) begin
         if (script[i].is_write) begin
            wait_answers_out();
            csr_write(script[i].reg_idx, script[i].reg_data);
         end else begin
            send_req(script[i]);
         end
      end

      // register extremes: endless stream, widest window of single-column rows
      run_phase('hffff, 'hffff, 1024, 1, 50, 4, 0);
      run_phase(12, 0, 1024, 1, 50, 12, 0);
      // full-width rows until the store overflows, with a long response stall
      run_phase(5, 0, 5, 1024, 0, 30, 1);

      // random geometry phases
      random_base = served_items;
      while (served_items - random_base < RANDOM_ITEMS) begin
         case ($urandom_range(0, 15))
            0:       src = 0;
            1:       src = 'hffff;
            default: src = $urandom_range(1, 10);
         endcase
         src_small = (src > 12) ? 12 : src;
         wb = ($urandom_range(0, 15) == 0) ? 'hffff : $urandom_range(0, src_small + 2);
         case ($urandom_range(0, 15))
            0:       wr = 1024;
            1:       wr = 0;
            default: wr = $urandom_range(1, 8);
         endcase
         wd = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
         run_phase(src, wb, wr, wd, 25 * $urandom_range(0, 4), $urandom_range(4, 12), 0);
      end

      wait_answers_out();
      repeat (16) @(posedge clock);
      $display("covered %0d geometry phases: %0d loads, %0d lookups, %0d restarts, %0d idle ops",
               n_phase, n_load, n_query, n_restart, n_idle);
      $display("responses seen: %0d hits, %0d overflow, %0d ignored loads, %0d early lookups",
               n_hits_seen, n_overflow_seen, n_extra_seen, n_early_seen);
      if (mismatch_count == 0 && csr_answers.size() == 0) begin
         $display("dense_to_csr_builder_with_lookup verification clean");
      end else begin
         $display("dense_to_csr_builder_with_lookup verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/dcsr_pkg.sv
sv/dcsr_ctrl.sv
sv/dcsr_datapath.sv
sv/dense_to_csr_builder_with_lookup.sv
tb/sv/tb_dense_to_csr_builder_with_lookup.sv
